// ===== rtl/swd_pkg.sv =====
`default_nettype none

package swd_pkg;

  // Table sizes.
  localparam int SHAPER_TABLE_ADDR_BITS = 10;
  localparam int TONE_TABLE_ADDR_BITS   = 6;
  localparam int SHP_N   = 1 << SHAPER_TABLE_ADDR_BITS;
  localparam int TONE_N  = 1 << TONE_TABLE_ADDR_BITS;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Q15 constants.
  localparam logic [15:0] Q15_ONE   = 16'd32768;
  localparam logic [15:0] FUZZ_KNEE = 16'd22938;
  localparam logic [15:0] FUZZ_SPAN = 16'd9830;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHAPER_MODE = 3'd0,
    REG_DRIVE_GAIN  = 3'd1,
    REG_TONE        = 3'd2,
    REG_WET_MIX     = 3'd3,
    REG_ENABLED     = 3'd4
  } cfg_reg_t;

  // Shaper modes.
  typedef enum logic [1:0] {
    MODE_SOFT = 2'd0,
    MODE_HARD = 2'd1,
    MODE_TUBE = 2'd2,
    MODE_FUZZ = 2'd3
  } shaper_mode_t;

  typedef logic [15:0] shp_tab_t [SHP_N];
  typedef logic [15:0] tone_tab_t [TONE_N];

  // Restoring long division for table building; returns the quotient, or the
  // remainder when want_rem is set.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d,
                                             input bit want_rem);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return want_rem ? r : q;
  endfunction

  // e^x in Q30 by a Taylor series, for arguments up to about 2.3.
  function automatic longint unsigned exp_pos_q30(input longint unsigned x);
    longint unsigned sum;
    longint unsigned term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * x) >> 30, longint'(k), 1'b0);
      sum  = sum + term;
    end
    return sum;
  endfunction

  // e^-x in Q30, rounded to nearest.
  function automatic longint unsigned exp_neg_q30(input longint unsigned x);
    longint unsigned e;
    e = exp_pos_q30(x);
    return udiv64((64'd1 << 60) + (e >> 1), e, 1'b0);
  endfunction

  // Shaper table over [0,8): tanh when want_tanh is set, else e^-x.
  function automatic shp_tab_t build_shp_tab(input bit want_tanh);
    shp_tab_t tab;
    longint unsigned h;
    longint unsigned r1;
    longint unsigned r2;
    longint unsigned a1;
    longint unsigned a2;
    longint unsigned one;
    longint unsigned v;
    one = 64'd1 << 30;
    h   = (64'd8 << 30) >> SHAPER_TABLE_ADDR_BITS;
    r1  = exp_neg_q30(h);
    r2  = exp_neg_q30(2 * h);
    a1  = one;
    a2  = one;
    for (int i = 0; i < SHP_N; i++) begin
      if (want_tanh) begin
        v = udiv64(((one - a2) << 15) + ((one + a2) >> 1), one + a2, 1'b0);
      end else begin
        v = (a1 + (64'd1 << 14)) >> 15;
      end
      tab[i] = v[15:0];
      a1 = (a1 * r1 + (64'd1 << 29)) >> 30;
      a2 = (a2 * r2 + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  // Lowpass coefficient alpha = 1 - e^-w in Q15 over the tone range.
  function automatic tone_tab_t build_alpha_tab();
    tone_tab_t tab;
    longint unsigned m;
    longint unsigned den;
    longint unsigned num;
    longint unsigned q1;
    longint unsigned rem;
    longint unsigned w;
    longint unsigned e;
    longint unsigned v;
    m   = longint'(TONE_N - 1);
    den = 64'd100000 * 64'd44100 * m;
    for (int i = 0; i < TONE_N; i++) begin
      num = 64'd628318 * (64'd800 * m + 64'd15000 * longint'(i));
      q1  = udiv64(num << 15, den, 1'b0);
      rem = udiv64(num << 15, den, 1'b1);
      w   = (q1 << 15) + udiv64(rem << 15, den, 1'b0);
      e   = exp_neg_q30(w);
      v   = 64'd32768 - ((e + (64'd1 << 14)) >> 15);
      tab[i] = v[15:0];
    end
    return tab;
  endfunction

  // Shaper table address of a Q15 argument; past 8.0 the last entry is used.
  function automatic logic [SHAPER_TABLE_ADDR_BITS-1:0] shp_addr(input logic [21:0] v);
    logic [SHAPER_TABLE_ADDR_BITS-1:0] a;
    if (v[21:18] != 4'd0) begin
      a = '1;
    end else begin
      a = v[17 -: SHAPER_TABLE_ADDR_BITS];
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stereo_waveshaper_distortion.sv =====
// Stereo waveshaping distortion with tone lowpass and dry/wet mix.
// Input stream: one stereo frame per transfer, left sample in tdata[15:0],
// right sample in tdata[31:16], buffer end marker on tlast. The output
// stream carries the processed frame in the same layout with the marker.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data while
// no frame is in flight; the user is bound to this, the block does not enforce it.
// Each frame is worked channel by channel on one shared multiply-accumulate
// unit that takes the multiplier four bits per cycle. The next frame is taken
// in the cycle after the result has moved into the output register. With the
// block disabled a frame passes through unchanged.
// Reset restores the default registers, clears both lowpass states and
// empties the output register. A stalled receiver holds the result in the
// output register; one more frame may be taken and worked, and it then waits
// until the output register is free.
`default_nettype none

module stereo_waveshaper_distortion (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,   // left_in, right_in
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,   // left_out, right_out
  output logic                             m_axis_tlast,
  input  logic                             cfg_wr_en,
  input  logic [swd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [swd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import swd_pkg::*;

  localparam int AW    = 26;          // multiplicand width
  localparam int SHW   = AW + 12;     // multiplicand after three digit shifts
  localparam int ACC_W = 44;
  localparam int TP_W  = 17 + TONE_TABLE_ADDR_BITS;

  localparam shp_tab_t  TANH_ROM  = build_shp_tab(1'b1);
  localparam shp_tab_t  EXP_ROM   = build_shp_tab(1'b0);
  localparam tone_tab_t ALPHA_ROM = build_alpha_tab();

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_DRIVE, ST_ADDR, ST_RWAIT, ST_SHAPE, ST_FWAIT,
    ST_FSTART, ST_FMUL, ST_FDONE, ST_SIGN, ST_LPSTART, ST_LPMUL, ST_LPDONE,
    ST_BL1, ST_BL2, ST_BLDONE, ST_MX1, ST_MX2, ST_MXDONE, ST_DONE
  } state_t;

  // Configuration registers.
  logic [1:0]  shaper_mode;
  logic [12:0] drive_gain;
  logic [15:0] tone;
  logic [15:0] wet_mix;
  logic        enabled;

  // Sequencer and datapath registers.
  state_t                           state;
  logic                             ch;
  logic signed [15:0]               in_l;
  logic signed [15:0]               in_r;
  logic                             in_last;
  logic signed [15:0]               x;
  logic [15:0]                      y;
  logic signed [23:0]               d22;
  logic signed [23:0]               lp_l;
  logic signed [23:0]               lp_r;
  logic signed [AW-1:0]             t22;
  logic [15:0]                      tn_r;
  logic [15:0]                      mx_r;
  logic [15:0]                      alpha_r;
  logic signed [15:0]               res_l;
  logic [SHAPER_TABLE_ADDR_BITS-1:0] rom_addr;
  logic [15:0]                      tanh_q;
  logic [15:0]                      exp_q;

  // Digit-serial multiply-accumulate unit.
  logic signed [SHW-1:0]            a_sh;
  logic [15:0]                      b_sh;
  logic [1:0]                       cnt;
  logic signed [ACC_W-1:0]          acc;
  logic signed [SHW+4:0]            mac_step;
  logic signed [ACC_W-1:0]          mac_sum;

  // Combinational helpers.
  logic signed [15:0]               in_l_c;
  logic signed [15:0]               in_r_c;
  logic signed [15:0]               sel_c;
  logic [16:0]                      mag_c;
  logic [20:0]                      d_c;
  logic [21:0]                      arg_c;
  logic [13:0]                      dz_c;
  logic [15:0]                      z_c;
  logic signed [16:0]               sh_c;
  logic signed [23:0]               lp_cur;
  logic signed [29:0]               s_sum;
  logic signed [23:0]               s_sat;
  logic signed [21:0]               o_c;
  logic signed [15:0]               o_sat;
  logic [15:0]                      tn_c;
  logic [15:0]                      mx_c;
  logic [TP_W-1:0]                  tone_prod;
  logic                             mac_last;

  assign in_l_c = s_axis_tdata[15:0];
  assign in_r_c = s_axis_tdata[31:16];
  assign s_axis_tready = (state == ST_IDLE);

  // One digit of the multiplier per cycle.
  assign mac_step = a_sh * $signed({1'b0, b_sh[3:0]});
  assign mac_sum  = acc + ACC_W'(mac_step);
  assign mac_last = (cnt == 2'd3);

  // Clamped tone and mix, and the tone table index rounded to nearest.
  assign tn_c = (tone > Q15_ONE) ? Q15_ONE : tone;
  assign mx_c = (wet_mix > Q15_ONE) ? Q15_ONE : wet_mix;
  assign tone_prod = TP_W'(tn_c) * TP_W'(TONE_N - 1) + TP_W'(16384);

  // Channel select and magnitude.
  assign sel_c = ch ? in_r : in_l;
  assign mag_c = sel_c[15] ? (17'd0 - {sel_c[15], sel_c}) : {1'b0, sel_c};

  // Driven magnitude and shaper argument.
  assign d_c   = acc[28:8];
  assign arg_c = (shaper_mode == MODE_FUZZ) ? {d_c, 1'b0} : {1'b0, d_c};

  // Fuzz knee argument.
  assign dz_c = 14'(tanh_q - FUZZ_KNEE);
  assign z_c  = {dz_c, 2'b00} + {2'b00, dz_c};

  // Sign restored on the shaped value.
  assign sh_c = x[15] ? (17'sd0 - $signed({1'b0, y})) : $signed({1'b0, y});

  // Lowpass update with saturation.
  assign lp_cur = ch ? lp_r : lp_l;
  assign s_sum  = 30'(lp_cur) + 30'($signed(acc[ACC_W-1:15]));
  always_comb begin
    if (s_sum > 30'sd8388607) begin
      s_sat = 24'sh7FFFFF;
    end else if (s_sum < -30'sd8388608) begin
      s_sat = 24'sh800000;
    end else begin
      s_sat = s_sum[23:0];
    end
  end

  // Final rounding shift and 16-bit saturation.
  assign o_c = acc[ACC_W-1:22];
  always_comb begin
    if (o_c > 22'sd32767) begin
      o_sat = 16'sh7FFF;
    end else if (o_c < -22'sd32768) begin
      o_sat = 16'sh8000;
    end else begin
      o_sat = o_c[15:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      shaper_mode <= MODE_SOFT;
      drive_gain  <= 13'd1024;
      tone        <= 16'd16384;
      wet_mix     <= 16'd26214;
      enabled     <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SHAPER_MODE: shaper_mode <= cfg_data[1:0];
        REG_DRIVE_GAIN:  drive_gain  <= cfg_data[12:0];
        REG_TONE:        tone        <= cfg_data;
        REG_WET_MIX:     wet_mix     <= cfg_data;
        REG_ENABLED:     enabled     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Shaper table read port, registered.
  always_ff @(posedge clk) begin
    tanh_q <= TANH_ROM[rom_addr];
    exp_q  <= EXP_ROM[rom_addr];
  end

  // Sequencer, datapath and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ch            <= 1'b0;
      lp_l          <= '0;
      lp_r          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_l    <= in_l_c;
            in_r    <= in_r_c;
            in_last <= s_axis_tlast;
            tn_r    <= tn_c;
            mx_r    <= mx_c;
            alpha_r <= ALPHA_ROM[tone_prod[15 +: TONE_TABLE_ADDR_BITS]];
            ch      <= 1'b0;
            if (enabled) begin
              state <= ST_LOAD;
            end else begin
              res_l <= in_l_c;
              state <= ST_DONE;
            end
          end
        end
        ST_LOAD: begin
          x     <= sel_c;
          a_sh  <= SHW'(mag_c);
          b_sh  <= {3'b000, drive_gain};
          acc   <= '0;
          cnt   <= '0;
          state <= ST_DRIVE;
        end
        ST_DRIVE: begin
          acc  <= mac_sum;
          a_sh <= a_sh <<< 4;
          b_sh <= b_sh >> 4;
          cnt  <= cnt + 2'd1;
          if (mac_last) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          rom_addr <= shp_addr(arg_c);
          if (shaper_mode == MODE_HARD) begin
            y     <= (d_c > 21'(Q15_ONE)) ? Q15_ONE : d_c[15:0];
            state <= ST_SIGN;
          end else begin
            state <= ST_RWAIT;
          end
        end
        ST_RWAIT: begin
          state <= ST_SHAPE;
        end
        ST_SHAPE: begin
          case (shaper_mode)
            MODE_TUBE: begin
              y     <= Q15_ONE - exp_q;
              state <= ST_SIGN;
            end
            MODE_FUZZ: begin
              y <= tanh_q;
              if (tanh_q > FUZZ_KNEE) begin
                rom_addr <= shp_addr({6'd0, z_c});
                state    <= ST_FWAIT;
              end else begin
                state <= ST_SIGN;
              end
            end
            default: begin
              y     <= tanh_q;
              state <= ST_SIGN;
            end
          endcase
        end
        ST_FWAIT: begin
          state <= ST_FSTART;
        end
        ST_FSTART: begin
          a_sh  <= SHW'(tanh_q);
          b_sh  <= FUZZ_SPAN;
          acc   <= '0;
          cnt   <= '0;
          state <= ST_FMUL;
        end
        ST_FMUL: begin
          acc  <= mac_sum;
          a_sh <= a_sh <<< 4;
          b_sh <= b_sh >> 4;
          cnt  <= cnt + 2'd1;
          if (mac_last) begin
            state <= ST_FDONE;
          end
        end
        ST_FDONE: begin
          y     <= FUZZ_KNEE + acc[30:15];
          state <= ST_SIGN;
        end
        ST_SIGN: begin
          d22   <= {sh_c, 7'd0};
          state <= ST_LPSTART;
        end
        ST_LPSTART: begin
          a_sh  <= SHW'(AW'(d22) - AW'(lp_cur));
          b_sh  <= alpha_r;
          acc   <= ACC_W'(1 << 14);
          cnt   <= '0;
          state <= ST_LPMUL;
        end
        ST_LPMUL: begin
          acc  <= mac_sum;
          a_sh <= a_sh <<< 4;
          b_sh <= b_sh >> 4;
          cnt  <= cnt + 2'd1;
          if (mac_last) begin
            state <= ST_LPDONE;
          end
        end
        ST_LPDONE: begin
          if (ch) begin
            lp_r <= s_sat;
          end else begin
            lp_l <= s_sat;
          end
          a_sh  <= SHW'(s_sat);
          b_sh  <= tn_r;
          acc   <= ACC_W'(1 << 14);
          cnt   <= '0;
          state <= ST_BL1;
        end
        ST_BL1: begin
          acc <= mac_sum;
          cnt <= cnt + 2'd1;
          if (mac_last) begin
            // Second term of the tone blend accumulates on top.
            a_sh  <= SHW'(d22);
            b_sh  <= Q15_ONE - tn_r;
            state <= ST_BL2;
          end else begin
            a_sh <= a_sh <<< 4;
            b_sh <= b_sh >> 4;
          end
        end
        ST_BL2: begin
          acc  <= mac_sum;
          a_sh <= a_sh <<< 4;
          b_sh <= b_sh >> 4;
          cnt  <= cnt + 2'd1;
          if (mac_last) begin
            state <= ST_BLDONE;
          end
        end
        ST_BLDONE: begin
          t22   <= acc[AW+14:15];
          a_sh  <= SHW'($signed({x, 7'd0}));
          b_sh  <= Q15_ONE - mx_r;
          acc   <= ACC_W'(1 << 21);
          cnt   <= '0;
          state <= ST_MX1;
        end
        ST_MX1: begin
          acc <= mac_sum;
          cnt <= cnt + 2'd1;
          if (mac_last) begin
            // Wet term accumulates on top of the dry term.
            a_sh  <= SHW'(t22);
            b_sh  <= mx_r;
            state <= ST_MX2;
          end else begin
            a_sh <= a_sh <<< 4;
            b_sh <= b_sh >> 4;
          end
        end
        ST_MX2: begin
          acc  <= mac_sum;
          a_sh <= a_sh <<< 4;
          b_sh <= b_sh >> 4;
          cnt  <= cnt + 2'd1;
          if (mac_last) begin
            state <= ST_MXDONE;
          end
        end
        ST_MXDONE: begin
          if (ch) begin
            in_r  <= o_sat;
            state <= ST_DONE;
          end else begin
            res_l <= o_sat;
            ch    <= 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_DONE: begin
          // Move the result into the output register once it is free.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {in_r, res_l};
            m_axis_tlast  <= in_last;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swd_checker.sv =====
`default_nettype none

module swd_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer withdrawn while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A frame is worked alone: no second input transfer right after one.
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a frame is in work");

  // A new result only appears while the input side is closed.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a frame in work");

endmodule

bind stereo_waveshaper_distortion swd_checker u_swd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
